FILE: design/tlps_pkg.sv
package tlps_pkg;

  // Configuration port sizes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 8'd3;

  // Register reset values.
  localparam logic [7:0] HOLD_RESET     = 8'd5;
  localparam logic [7:0] STEP_RESET     = 8'd1;
  localparam logic [7:0] COUNT_RESET    = 8'd10;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd1;

  // Car lamp group bits.
  localparam logic [2:0] LAMP_GREEN  = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_RED    = 3'b100;

  // Second lamp group pins.
  localparam logic [2:0] PIN0 = 3'b001;
  localparam logic [2:0] PIN1 = 3'b010;
  localparam logic [2:0] PIN2 = 3'b100;

  typedef enum logic [7:0] {
    PH_GREEN    = 8'b0000_0001,
    PH_Y_GREEN  = 8'b0000_0010,
    PH_RED      = 8'b0000_0100,
    PH_Y_RED    = 8'b0000_1000,
    PH_P_BLINK  = 8'b0001_0000,
    PH_P_RED    = 8'b0010_0000,
    PH_P_YELLOW = 8'b0100_0000,
    PH_P_GREEN  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] hold_seconds;
    logic [7:0] blink_step_seconds;
    logic [7:0] blink_count;
    logic [7:0] debounce_seconds;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic button_level;
  } item_t;

  typedef struct packed {
    logic [2:0] lamps_a;
    logic [2:0] lamps_b;
    logic       pedestrian_active;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] secs;
    logic [7:0] toggles;
    logic [2:0] lamps_a;
    logic [2:0] lamps_b;
  } light_t;

  // A timing value of zero behaves as one.
  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic is_yellow(input phase_t p);
    return (p == PH_Y_GREEN) || (p == PH_Y_RED) || (p == PH_P_BLINK) || (p == PH_P_YELLOW);
  endfunction

  function automatic logic is_pedestrian(input phase_t p);
    return (p == PH_P_BLINK) || (p == PH_P_RED) || (p == PH_P_YELLOW) || (p == PH_P_GREEN);
  endfunction

  function automatic phase_t next_phase(input phase_t p);
    phase_t n;
    case (p)
      PH_GREEN:    n = PH_Y_GREEN;
      PH_Y_GREEN:  n = PH_RED;
      PH_RED:      n = PH_Y_RED;
      PH_Y_RED:    n = PH_GREEN;
      PH_P_BLINK:  n = PH_P_RED;
      PH_P_RED:    n = PH_P_YELLOW;
      PH_P_YELLOW: n = PH_P_GREEN;
      PH_P_GREEN:  n = PH_Y_GREEN;
      default:     n = PH_GREEN;
    endcase
    return n;
  endfunction

  // Light state right after entering a phase.
  function automatic light_t enter_phase(input phase_t p, input cfg_t cfg);
    light_t l;
    l.phase   = p;
    l.toggles = 8'd0;
    l.secs    = at_least_one(cfg.hold_seconds);
    case (p)
      PH_GREEN, PH_P_GREEN: begin
        l.lamps_a = LAMP_GREEN;
        l.lamps_b = PIN2;
      end
      PH_RED, PH_P_RED: begin
        l.lamps_a = LAMP_RED;
        l.lamps_b = PIN0;
      end
      PH_Y_GREEN: begin
        l.lamps_a = LAMP_YELLOW;
        l.lamps_b = PIN2;
      end
      PH_Y_RED, PH_P_YELLOW: begin
        l.lamps_a = LAMP_YELLOW;
        l.lamps_b = PIN0;
      end
      default: begin
        l.lamps_a = LAMP_YELLOW;
        l.lamps_b = PIN1;
      end
    endcase
    if (is_yellow(p)) begin
      l.secs    = at_least_one(cfg.blink_step_seconds);
      l.toggles = at_least_one(cfg.blink_count);
    end
    return l;
  endfunction

endpackage

FILE: design/tlps_cfg.sv
module tlps_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tlps_pkg::cfg_t                 cfg
);
  import tlps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_HOLD:     cfg_nxt.hold_seconds       = cfg_wdata;
        CFG_IDX_STEP:     cfg_nxt.blink_step_seconds = cfg_wdata;
        CFG_IDX_COUNT:    cfg_nxt.blink_count        = cfg_wdata;
        CFG_IDX_DEBOUNCE: cfg_nxt.debounce_seconds   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_seconds       <= HOLD_RESET;
      cfg_r.blink_step_seconds <= STEP_RESET;
      cfg_r.blink_count        <= COUNT_RESET;
      cfg_r.debounce_seconds   <= DEBOUNCE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/tlps_in_stage.sv
module tlps_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_tick,
  input  logic            in_button_level,
  input  logic            dn_ready,
  output logic            go,
  output tlps_pkg::item_t item
);
  import tlps_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  // The held request moves on when the result register has room.
  assign go       = valid_r && dn_ready;
  assign in_stall = valid_r && !dn_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, loaded on every accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.tick         <= in_tick;
      item_r.button_level <= in_button_level;
    end
  end

  assign item = item_r;

endmodule

FILE: design/tlps_core.sv
module tlps_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  tlps_pkg::item_t   item,
  input  tlps_pkg::cfg_t    cfg,
  output tlps_pkg::result_t res
);
  import tlps_pkg::*;

  light_t     light_r;
  light_t     light_nxt;
  light_t     ped_entry;
  light_t     step_entry;
  logic [7:0] deb_left_r;
  logic [7:0] deb_left_nxt;
  logic       deb_run_r;
  logic       deb_run_nxt;
  logic       last_btn_r;
  logic       last_btn_nxt;
  logic       confirm;

  // Debounce: a falling edge starts the count (or confirms at once if the debounce is zero), ticks run it down.
  always_comb begin
    confirm      = 1'b0;
    deb_left_nxt = deb_left_r;
    deb_run_nxt  = deb_run_r;
    if (deb_run_r) begin
      if (item.tick) begin
        deb_left_nxt = (deb_left_r != 8'd0) ? deb_left_r - 8'd1 : 8'd0;
        if (deb_left_nxt == 8'd0) begin
          deb_run_nxt = 1'b0;
          confirm     = !item.button_level;
        end
      end
    end else if (last_btn_r && !item.button_level) begin
      if (cfg.debounce_seconds == 8'd0) begin
        confirm = 1'b1;
      end else begin
        deb_left_nxt = cfg.debounce_seconds;
        deb_run_nxt  = 1'b1;
      end
    end
    last_btn_nxt = item.button_level;
  end

  // Phase sequencing: a confirmed press during car green or the yellow after it wins over the tick.
  always_comb begin
    ped_entry  = enter_phase(PH_P_BLINK, cfg);
    step_entry = enter_phase(next_phase(light_r.phase), cfg);
    light_nxt  = light_r;
    if (confirm && ((light_r.phase == PH_GREEN) || (light_r.phase == PH_Y_GREEN))) begin
      light_nxt = ped_entry;
    end else if (item.tick) begin
      if (light_r.secs > 8'd1) begin
        light_nxt.secs = light_r.secs - 8'd1;
      end else if (is_yellow(light_r.phase) && (light_r.toggles > 8'd1)) begin
        light_nxt.toggles = light_r.toggles - 8'd1;
        light_nxt.secs    = at_least_one(cfg.blink_step_seconds);
        light_nxt.lamps_a = light_r.lamps_a ^ LAMP_YELLOW;
        if (light_r.phase == PH_P_BLINK) begin
          light_nxt.lamps_b = light_r.lamps_b ^ PIN1;
        end
      end else begin
        light_nxt = step_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r.phase   <= PH_GREEN;
      light_r.secs    <= HOLD_RESET;
      light_r.toggles <= 8'd0;
      light_r.lamps_a <= LAMP_GREEN;
      light_r.lamps_b <= PIN2;
      deb_left_r      <= 8'd0;
      deb_run_r       <= 1'b0;
      last_btn_r      <= 1'b1;
    end else if (go) begin
      light_r    <= light_nxt;
      deb_left_r <= deb_left_nxt;
      deb_run_r  <= deb_run_nxt;
      last_btn_r <= last_btn_nxt;
    end
  end

  // The result shows the lamps after this request's update.
  assign res.lamps_a           = light_nxt.lamps_a;
  assign res.lamps_b           = light_nxt.lamps_b;
  assign res.pedestrian_active = is_pedestrian(light_nxt.phase);

  // State only moves when a request passes through.
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(light_r) && $stable(deb_run_r))
    else $error("light state changed without a request");

  // An idle debounce always sits at zero.
  a_debounce_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !deb_run_r |-> (deb_left_r == 8'd0))
    else $error("debounce count left over while idle");

  // Car green and car red are never lit together.
  a_no_green_red: assert property (@(posedge clk) disable iff (!rst_n)
    !(light_r.lamps_a[0] && light_r.lamps_a[2]))
    else $error("car green and red lit together");

endmodule

FILE: design/tlps_out_stage.sv
module tlps_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  tlps_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              dn_ready,
  output tlps_pkg::result_t res_out
);
  import tlps_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // Room for a new result when empty or when the held one is taken.
  assign dn_ready  = !valid_r || !out_stall;
  assign valid_nxt = go || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

  // Every request that leaves the input register shows up as a result.
  a_go_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> valid_r)
    else $error("request lost between stages");

endmodule

FILE: design/traffic_light_pedestrian_sequencer.sv
// A request goes from the input register to the result register, which drives the outputs.
// One request per cycle unless stalled; the input register frees as the result register loads.
// A stalled result stays in the result register while one more request waits in the input.
// Reset (rst_n low, synchronous) empties both registers, restores the register defaults
// and starts in car green with the button seen as released.
module traffic_light_pedestrian_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_tick,
  input  logic                           in_button_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_lamps_a,
  output logic [2:0]                     out_lamps_b,
  output logic                           out_pedestrian_active,
  input  logic                           cfg_wr_en,
  input  logic [tlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tlps_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  result_t res_out;
  logic    go;
  logic    dn_ready;

  tlps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tlps_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tick         (in_tick),
    .in_button_level (in_button_level),
    .dn_ready        (dn_ready),
    .go              (go),
    .item            (item)
  );

  tlps_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  tlps_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dn_ready  (dn_ready),
    .res_out   (res_out)
  );

  assign out_lamps_a           = res_out.lamps_a;
  assign out_lamps_b           = res_out.lamps_b;
  assign out_pedestrian_active = res_out.pedestrian_active;

endmodule

FILE: sim/traffic_light_pedestrian_sequencer_tb.sv
`timescale 1ns / 1ps

module traffic_light_pedestrian_sequencer_tb;
  import tlps_pkg::*;

  // Directed request: tick, button level, and an optional fixed expectation.
  typedef struct packed {
    logic    tick;
    logic    btn;
    logic    fixed;
    result_t want;
  } dir_row_t;

  localparam result_t CAR_GO    = '{LAMP_GREEN, PIN2, 1'b0};
  localparam result_t PED_START = '{LAMP_YELLOW, PIN1, 1'b1};
  localparam result_t NO_LAMPS  = '0;
  localparam logic [CFG_IDX_W-1:0] BAD_IDX_TOP = 8'hFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_tick = 1'b0;
  logic                  in_button_level = 1'b1;
  logic                  out_stall = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [2:0]            out_lamps_a;
  logic [2:0]            out_lamps_b;
  logic                  out_pedestrian_active;

  // Predicted light state and the register copies it runs on.
  phase_t     ph_now;
  logic [7:0] secs_left;
  logic [7:0] steps_left;
  logic [7:0] deb_left;
  logic [2:0] car_lamps;
  logic [2:0] side_lamps;
  logic       deb_busy;
  logic       btn_prev;
  logic [7:0] hold_r;
  logic [7:0] step_r;
  logic [7:0] count_r;
  logic [7:0] deb_r;

  result_t    expected_lamps[$];
  dir_row_t   dir_rows[$];
  result_t    mon_want;
  int         mismatch_count = 0;
  int         quiet_in = 0;
  int         quiet_out = 0;
  int         stall_run = 0;

  traffic_light_pedestrian_sequencer u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_tick               (in_tick),
    .in_button_level       (in_button_level),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_lamps_a           (out_lamps_a),
    .out_lamps_b           (out_lamps_b),
    .out_pedestrian_active (out_pedestrian_active),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A timing register of zero counts as one.
  function automatic logic [7:0] min_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic blinks(input phase_t p);
    return p inside {PH_Y_GREEN, PH_Y_RED, PH_P_BLINK, PH_P_YELLOW};
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Set up lamps and timers on entry to a phase.
  function automatic void load_phase(input phase_t p);
    ph_now     = p;
    steps_left = 8'd0;
    case (p)
      PH_GREEN, PH_P_GREEN: begin
        car_lamps  = LAMP_GREEN;
        side_lamps = PIN2;
        secs_left  = min_one(hold_r);
      end
      PH_RED, PH_P_RED: begin
        car_lamps  = LAMP_RED;
        side_lamps = PIN0;
        secs_left  = min_one(hold_r);
      end
      PH_Y_GREEN: begin
        car_lamps  = LAMP_YELLOW;
        side_lamps = PIN2;
      end
      PH_Y_RED, PH_P_YELLOW: begin
        car_lamps  = LAMP_YELLOW;
        side_lamps = PIN0;
      end
      default: begin
        car_lamps  = LAMP_YELLOW;
        side_lamps = PIN1;
      end
    endcase
    if (blinks(p)) begin
      secs_left  = min_one(step_r);
      steps_left = min_one(count_r);
    end
  endfunction

  // Advance the predicted lights by one request and return the lamps it shows.
  function automatic result_t predict_lamps(input logic t, input logic b);
    logic    confirm;
    phase_t  nxt;
    result_t r;
    confirm = 1'b0;
    // The debounce counts ticks; the button level at its end decides the press.
    if (deb_busy) begin
      if (t) begin
        if (deb_left > 8'd0) deb_left--;
        if (deb_left == 8'd0) begin
          deb_busy = 1'b0;
          confirm  = !b;
        end
      end
    end else if (btn_prev && !b) begin
      if (deb_r == 8'd0) begin
        confirm = 1'b1;
      end else begin
        deb_left = deb_r;
        deb_busy = 1'b1;
      end
    end
    btn_prev = b;

    // A confirmed press only counts while the cars have green or the yellow after it.
    if (confirm && (ph_now == PH_GREEN || ph_now == PH_Y_GREEN)) begin
      load_phase(PH_P_BLINK);
    end else if (t) begin
      if (secs_left > 8'd1) begin
        secs_left--;
      end else if (blinks(ph_now) && steps_left > 8'd1) begin
        steps_left--;
        secs_left = min_one(step_r);
        car_lamps ^= LAMP_YELLOW;
        if (ph_now == PH_P_BLINK) side_lamps ^= PIN1;
      end else begin
        case (ph_now)
          PH_GREEN:    nxt = PH_Y_GREEN;
          PH_Y_GREEN:  nxt = PH_RED;
          PH_RED:      nxt = PH_Y_RED;
          PH_Y_RED:    nxt = PH_GREEN;
          PH_P_BLINK:  nxt = PH_P_RED;
          PH_P_RED:    nxt = PH_P_YELLOW;
          PH_P_YELLOW: nxt = PH_P_GREEN;
          default:     nxt = PH_Y_GREEN;
        endcase
        load_phase(nxt);
      end
    end

    r.lamps_a           = car_lamps;
    r.lamps_b           = side_lamps;
    r.pedestrian_active = ph_now inside {PH_P_BLINK, PH_P_RED, PH_P_YELLOW, PH_P_GREEN};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Offer one request, wait for it to be taken, then log what it should show.
  task automatic send_request(input logic t, input logic b, input logic fixed,
                              input result_t want);
    int      gap;
    result_t pred;
    if (quiet_in > 0) begin
      quiet_in--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(99) == 0) quiet_in = $urandom_range(40, 150);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_tick         <= t;
    in_button_level <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_lamps(t, b);
    expected_lamps.push_back(fixed ? want : pred);
  endtask

  // Stop offering requests and let every outstanding result come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_lamps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four timing registers, plus two writes to unused indexes.
  task automatic load_timing(input logic [7:0] h, input logic [7:0] s,
                             input logic [7:0] c, input logic [7:0] d);
    int k;
    for (k = 0; k < 6; k++) begin
      cfg_wr_en <= 1'b1;
      case (k)
        0: begin
          cfg_index <= CFG_IDX_HOLD;
          cfg_wdata <= h;
        end
        1: begin
          cfg_index <= CFG_IDX_STEP;
          cfg_wdata <= s;
        end
        2: begin
          cfg_index <= CFG_IDX_COUNT;
          cfg_wdata <= c;
        end
        3: begin
          cfg_index <= CFG_IDX_DEBOUNCE;
          cfg_wdata <= d;
        end
        4: begin
          cfg_index <= BAD_IDX_TOP;
          cfg_wdata <= CFG_DATA_W'($urandom_range(0, 255));
        end
        default: begin
          cfg_index <= CFG_IDX_W'($urandom_range(4, 255));
          cfg_wdata <= CFG_DATA_W'($urandom_range(0, 255));
        end
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    hold_r  = h;
    step_r  = s;
    count_r = c;
    deb_r   = d;
  endtask

  // Random ticks with button presses, aimed mostly at the car green phases.
  task automatic run_traffic(input int n, input int tick_pct);
    int   k;
    int   press_left;
    int   need;
    int   start_pct;
    logic t;
    logic b;
    press_left = 0;
    need = deb_r * 100 / tick_pct + 2;
    for (k = 0; k < n; k++) begin
      t = ($urandom_range(99) < tick_pct);
      start_pct = (ph_now == PH_GREEN || ph_now == PH_Y_GREEN) ? 6 : 1;
      if (press_left > 0) begin
        // Held press with occasional contact bounce.
        press_left--;
        b = ($urandom_range(99) < 4);
      end else if ($urandom_range(99) < start_pct) begin
        b = 1'b0;
        if ($urandom_range(99) < 75) press_left = $urandom_range(need, 2 * need + 10);
        else press_left = $urandom_range(0, need);
      end else begin
        b = ($urandom_range(99) >= 2);
      end
      send_request(t, b, 1'b0, NO_LAMPS);
    end
  endtask

  // Result stall: random stretches, with quiet spells of no stall at all.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (quiet_out > 0) begin
        quiet_out--;
      end else begin
        stall_run = gap_len();
        if ($urandom_range(99) == 0) quiet_out = $urandom_range(40, 150);
      end
    end
  end

  // Compare each result taken with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lamps.size() == 0) begin
        report_mismatch("result with nothing expected", int'(out_lamps_a), 0);
      end else begin
        mon_want = expected_lamps.pop_front();
        if (out_lamps_a !== mon_want.lamps_a)
          report_mismatch("lamps_a", int'(out_lamps_a), int'(mon_want.lamps_a));
        if (out_lamps_b !== mon_want.lamps_b)
          report_mismatch("lamps_b", int'(out_lamps_b), int'(mon_want.lamps_b));
        if (out_pedestrian_active !== mon_want.pedestrian_active)
          report_mismatch("pedestrian_active", int'(out_pedestrian_active),
                          int'(mon_want.pedestrian_active));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    // Predicted state after reset.
    hold_r     = HOLD_RESET;
    step_r     = STEP_RESET;
    count_r    = COUNT_RESET;
    deb_r      = DEBOUNCE_RESET;
    ph_now     = PH_GREEN;
    secs_left  = HOLD_RESET;
    steps_left = 8'd0;
    car_lamps  = LAMP_GREEN;
    side_lamps = PIN2;
    deb_left   = 8'd0;
    deb_busy   = 1'b0;
    btn_prev   = 1'b1;

    // Directed requests on the reset timing.
    dir_rows.push_back({1'b0, 1'b1, 1'b1, CAR_GO});
    dir_rows.push_back({1'b1, 1'b1, 1'b1, CAR_GO});
    // Falling edge starts the debounce.
    dir_rows.push_back({1'b0, 1'b0, 1'b1, CAR_GO});
    dir_rows.push_back({1'b0, 1'b1, 1'b0, NO_LAMPS});
    // Edge during a running debounce is ignored.
    dir_rows.push_back({1'b0, 1'b0, 1'b0, NO_LAMPS});
    // Released when the debounce ends, so no press.
    dir_rows.push_back({1'b1, 1'b1, 1'b0, NO_LAMPS});
    dir_rows.push_back({1'b0, 1'b0, 1'b0, NO_LAMPS});
    // Confirmed in car green: pedestrian blink starts and the tick is dropped.
    dir_rows.push_back({1'b1, 1'b0, 1'b1, PED_START});
    dir_rows.push_back({1'b1, 1'b0, 1'b0, NO_LAMPS});
    dir_rows.push_back({1'b0, 1'b1, 1'b0, NO_LAMPS});
    // Press confirmed during the pedestrian sequence is ignored.
    dir_rows.push_back({1'b0, 1'b0, 1'b0, NO_LAMPS});
    dir_rows.push_back({1'b1, 1'b0, 1'b0, NO_LAMPS});
    // Run the blink out into pedestrian red, which clears the side yellow.
    repeat (8) dir_rows.push_back({1'b1, 1'b1, 1'b0, NO_LAMPS});
    dir_rows.push_back({1'b1, 1'b0, 1'b0, NO_LAMPS});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].tick, dir_rows[i].btn, dir_rows[i].fixed, dir_rows[i].want);
    settle();

    // Random traffic over a range of timing settings, extremes among them.
    load_timing(8'd5, 8'd1, 8'd10, 8'd1);
    run_traffic(200, 60);
    settle();
    load_timing(8'd1, 8'd1, 8'd1, 8'd0);
    run_traffic(200, 50);
    settle();
    load_timing(8'd0, 8'd0, 8'd0, 8'd0);
    run_traffic(200, 40);
    settle();
    load_timing(8'd255, 8'd1, 8'd1, 8'd255);
    run_traffic(400, 100);
    settle();
    load_timing(8'd3, 8'd255, 8'd1, 8'd2);
    run_traffic(250, 100);
    settle();
    load_timing(8'd1, 8'd2, 8'd255, 8'd3);
    run_traffic(250, 100);
    settle();
    load_timing(8'd2, 8'd3, 8'd4, 8'd5);
    run_traffic(200, 30);
    settle();
    load_timing(8'd4, 8'd1, 8'd3, 8'd2);
    run_traffic(200, 80);
    settle();
    repeat (2) begin
      load_timing(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                  8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
      run_traffic(150, 70);
      settle();
    end

    if (mismatch_count == 0 && expected_lamps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
